FILE: rtl/core/csvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the delimited-record byte tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

   // Fixed control characters that end a record.
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Reset values of the configuration registers.
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE     = 2'd1;

   // Request command codes.
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Depth of the token queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Kind of a response token.
   typedef enum logic [2:0] {
      KIND_CONTENT    = 3'd0,
      KIND_FIELD      = 3'd1,
      KIND_RECORD     = 3'd2,
      KIND_CLEAN_END  = 3'd3,
      KIND_INCOMPLETE = 3'd4
   } kind_type;

   // Quoting state, one-hot.
   typedef enum logic [2:0] {
      MODE_OUT  = 3'b001,
      MODE_IN   = 3'b010,
      MODE_HELD = 3'b100
   } quote_mode_type;

   // One response token.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } token_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage : csvt_pkg
`default_nettype wire

FILE: rtl/core/csvt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_front
// Accepts request bytes, runs the quoting state machine and produces at most
// one token per request. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module csvt_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [csvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic                            req_cmd,
   input  wire logic [7:0]                      req_byte,
   input  csvt_pkg::queue_status_type           q_status,
   output logic                                 push,
   output csvt_pkg::token_type                  push_token
);
   import csvt_pkg::*;

   logic [7:0]     delimiter_ff, delimiter_in;
   logic [7:0]     quote_ff, quote_in;
   quote_mode_type mode_ff, mode_in;
   logic           field_empty_ff, field_empty_in;
   logic           record_open_ff, record_open_in;
   logic           after_cr_ff, after_cr_in;

   logic           accept;
   logic           emit;
   logic           do_outside;
   token_type      token;

   // A request is taken only when the queue has room for its token.
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && emit;
   assign push_token = token;

   // Configuration writes; indexes outside the list are ignored.
   always_comb begin
      delimiter_in = delimiter_ff;
      quote_in     = quote_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DELIMITER) begin
            delimiter_in = csr_data;
         end else if (csr_index == CSR_QUOTE) begin
            quote_in = csr_data;
         end
      end
   end

   // Classify the byte and compute the next parser state.
   always_comb begin
      mode_in        = mode_ff;
      field_empty_in = field_empty_ff;
      record_open_in = record_open_ff;
      after_cr_in    = after_cr_ff;
      emit           = 1'b0;
      do_outside     = 1'b0;
      token.kind     = KIND_CONTENT;
      token.data     = 8'd0;

      if (req_cmd == CMD_END) begin
         // Stream end reports whether a record was left open, then clears.
         emit           = 1'b1;
         token.kind     = record_open_ff ? KIND_INCOMPLETE : KIND_CLEAN_END;
         mode_in        = MODE_OUT;
         field_empty_in = 1'b1;
         record_open_in = 1'b0;
         after_cr_in    = 1'b0;
      end else begin
         after_cr_in = 1'b0;
         case (mode_ff)
            MODE_IN: begin
               if (req_byte == quote_ff) begin
                  mode_in = MODE_HELD;
               end else begin
                  field_empty_in = 1'b0;
                  emit           = 1'b1;
                  token.data     = req_byte;
               end
            end
            MODE_HELD: begin
               if (req_byte == quote_ff) begin
                  // A doubled quote is a literal quote.
                  mode_in        = MODE_IN;
                  field_empty_in = 1'b0;
                  emit           = 1'b1;
                  token.data     = req_byte;
               end else begin
                  mode_in    = MODE_OUT;
                  do_outside = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_OUT;
               // The LF of a CRLF pair is swallowed.
               do_outside = !(after_cr_ff && (req_byte == CHAR_LF));
            end
         endcase

         // Handling of a byte outside quotes; the quote test comes first.
         if (do_outside) begin
            if ((req_byte == quote_ff) && field_empty_ff) begin
               mode_in        = MODE_IN;
               record_open_in = 1'b1;
            end else if (req_byte == delimiter_ff) begin
               field_empty_in = 1'b1;
               record_open_in = 1'b1;
               emit           = 1'b1;
               token.kind     = KIND_FIELD;
            end else if ((req_byte == CHAR_LF) || (req_byte == CHAR_CR)) begin
               mode_in        = MODE_OUT;
               field_empty_in = 1'b1;
               record_open_in = 1'b0;
               after_cr_in    = (req_byte == CHAR_CR);
               emit           = 1'b1;
               token.kind     = KIND_RECORD;
            end else begin
               field_empty_in = 1'b0;
               record_open_in = 1'b1;
               emit           = 1'b1;
               token.data     = req_byte;
            end
         end
      end
   end

   // State registers; parser state moves only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff   <= DELIMITER_RESET;
         quote_ff       <= QUOTE_RESET;
         mode_ff        <= MODE_OUT;
         field_empty_ff <= 1'b1;
         record_open_ff <= 1'b0;
         after_cr_ff    <= 1'b0;
      end else begin
         delimiter_ff <= delimiter_in;
         quote_ff     <= quote_in;
         if (accept) begin
            mode_ff        <= mode_in;
            field_empty_ff <= field_empty_in;
            record_open_ff <= record_open_in;
            after_cr_ff    <= after_cr_in;
         end
      end
   end

endmodule : csvt_front
`default_nettype wire

FILE: rtl/core/csvt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_queue
// Short token queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csvt_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  csvt_pkg::token_type        push_token,
   input  wire logic                  pop,
   output csvt_pkg::token_type        pop_token,
   output csvt_pkg::queue_status_type status
);
   import csvt_pkg::*;

   token_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign pop_token    = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   // The front never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("token pushed into a full queue");

   // The back never reads from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("token popped from an empty queue");

   // The fill count tracks the pushes and pops.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == QUEUE_CNT_W'($past(count_ff)
         + QUEUE_CNT_W'($past(push)) - QUEUE_CNT_W'($past(pop))))
      else $error("queue fill count out of step");

   // Read and write pointers agree with the fill count.
   assert property (@(posedge clock) disable iff (reset)
      (status.empty || status.full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

endmodule : csvt_queue
`default_nettype wire

FILE: rtl/core/csvt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csvt_back
// Output register that takes tokens from the queue and presents them on the
// response channel.
// ----------------------------------------------------------------------------
module csvt_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  csvt_pkg::queue_status_type q_status,
   input  csvt_pkg::token_type        pop_token,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2:0]                 rsp_kind,
   output logic [7:0]                 rsp_byte
);
   import csvt_pkg::*;

   logic      valid_ff, valid_in;
   token_type token_ff;

   // Load a new token from a non-empty queue whenever the output stage is empty or being taken.
   assign pop = !q_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         token_ff <= pop_token;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = token_ff.kind;
   assign rsp_byte   = token_ff.data;

endmodule : csvt_back
`default_nettype wire

FILE: rtl/core/csv_byte_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// Streaming tokenizer for delimited records, one byte per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_tready is high and
// gives at most one response per request, in order: content bytes, field ends,
// record ends and a stream end that tells a clean end from an unfinished
// record. The quoting state machine updates on each accepted request, so a new
// request can follow every cycle. A response passes from the front into a
// four-entry token queue, then the output register. Requests that produce no
// response (quotes, the LF of a CRLF) still need room in the queue. When the
// response side stalls, the queue absorbs up to four tokens before req_tready
// drops. The user writes delimiter and quote characters through the csr port
// while the block is idle, which is not enforced; csr_ready is always high.
// ----------------------------------------------------------------------------
module csv_byte_tokenizer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Configuration write channel.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [csvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_data,
   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  wire logic [0:0]                      req_tuser,  // [0] cmd
   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,  // [7:0] out_byte
   output logic [2:0]                           rsp_tuser   // [2:0] kind
);
   import csvt_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   token_type        push_token;
   token_type        pop_token;

   assign csr_ready = 1'b1;

   // Front: configuration and quoting state machine.
   csvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .req_byte   (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_token (push_token)
   );

   // Token queue between the two halves.
   csvt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .pop_token  (pop_token),
      .status     (q_status)
   );

   // Back: response output register.
   csvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_token  (pop_token),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (rsp_tdata)
   );

endmodule : csv_byte_tokenizer
`default_nettype wire
